FILE: hw/rtl/drs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants of the range based dfa scanner.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int NUM_STATES      = 64;
    localparam int SLOTS_PER_STATE = 8;
    localparam int CHAR_BITS       = 16;
    localparam int POS_BITS        = 16;

    localparam int STATE_BITS = $clog2(NUM_STATES);
    localparam int LANE_BITS  = $clog2(SLOTS_PER_STATE);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // input item kind, carried on tuser
    typedef enum logic [1:0] {
        FUNC_LOAD_SLOT = 2'd0,
        FUNC_LOAD_FLAG = 2'd1,
        FUNC_TEXT      = 2'd2,
        FUNC_END       = 2'd3
    } func_t;

    typedef struct packed {
        logic                  valid;
        logic [CHAR_BITS-1:0]  low;
        logic [CHAR_BITS-1:0]  high;
        logic [STATE_BITS-1:0] target;
    } slot_t;

    typedef slot_t [SLOTS_PER_STATE-1:0] row_t;

    // table access request from the scan control
    typedef struct packed {
        logic                  rd_en;
        logic [STATE_BITS-1:0] rd_state;
        logic                  slot_we;
        logic                  acc_we;
        logic [STATE_BITS-1:0] wr_state;
        logic [LANE_BITS-1:0]  wr_lane;
        slot_t                 wr_slot;
        logic                  wr_acc;
    } tbl_req_t;

endpackage

FILE: hw/rtl/drs_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_table
// Transition table: one memory per slot lane plus an accept flag memory, all
// addressed by state. A full row is read in one access. Swept clear after
// reset.
// ----------------------------------------------------------------------------
module drs_table
    import drs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  tbl_req_t req,
    output row_t     rd_row,
    output logic     rd_acc,
    output logic     busy
);

    logic                  busy_reg, busy_next;
    logic [STATE_BITS-1:0] clr_addr_reg, clr_addr_next;

    always_comb begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == STATE_BITS'(NUM_STATES - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    for (genvar g = 0; g < SLOTS_PER_STATE; g++) begin : g_lane
        slot_t mem [NUM_STATES];
        slot_t data_reg;

        always_ff @(posedge aclk) begin
            if (busy_reg) begin
                mem[clr_addr_reg] <= '0;
            end else if (req.slot_we && req.wr_lane == LANE_BITS'(g)) begin
                mem[req.wr_state] <= req.wr_slot;
            end
            if (req.rd_en) begin
                data_reg <= mem[req.rd_state];
            end
        end

        assign rd_row[g] = data_reg;
    end

    logic acc_mem [NUM_STATES];
    logic acc_reg;

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            acc_mem[clr_addr_reg] <= 1'b0;
        end else if (req.acc_we) begin
            acc_mem[req.wr_state] <= req.wr_acc;
        end
        if (req.rd_en) begin
            acc_reg <= acc_mem[req.rd_state];
        end
    end

    assign rd_acc = acc_reg;
    assign busy   = busy_reg;

endmodule

FILE: hw/rtl/dfa_range_regex_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfa_range_regex_scanner_core
// Dfa matcher over character ranges: loads a slot table, scans text and
// reports the first immediate match or the best accepting point at end of text.
//
//  channel | signals                        | carries
//  --------+--------------------------------+---------------------------------
//  s_      | s_tvalid s_tready s_tdata      | table loads, text characters,
//          | s_tuser                        | end of text (kind on tuser)
//  m_      | m_tvalid m_tready m_tdata      | match report, at most one per item
//
// steps: a slot load is written from the idle state, and so is a flag load
// unless an accepting check is still open, which is first resolved in ST_FLAG;
// a text character is looked up in ST_LOOK and, when the attempt fails, retried
// from state 0 in ST_RETRY; end of text is reported from ST_EOT. once a text is
// reported its further characters and its end are handled in the idle state.
// each character needs one synchronous row read of the table memory plus one
// more for the retry. reset: the table memories are swept clear after reset, no
// item is taken meanwhile. a report waits in its state while the output register is still full.
// ----------------------------------------------------------------------------
module dfa_range_regex_scanner_core
    import drs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // state_index[5:0] slot_index[8:6] range_low[24:9] range_high[40:25]
    // target_state[46:41] accepting[47] text_char[63:48]
    input  logic [63:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // found[0] match_start[16:1] match_length[32:17] end_state[38:33] pad[39]
    output logic [39:0] m_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOOK  = 5'b00010,
        ST_RETRY = 5'b00100,
        ST_FLAG  = 5'b01000,
        ST_EOT   = 5'b10000
    } st_t;

    localparam int OUT_BITS = 40;

    // input fields
    func_t                 in_func;
    logic [STATE_BITS-1:0] in_state;
    logic [LANE_BITS-1:0]  in_slot;
    logic [CHAR_BITS-1:0]  in_low;
    logic [CHAR_BITS-1:0]  in_high;
    logic [STATE_BITS-1:0] in_target;
    logic                  in_acc;
    logic [CHAR_BITS-1:0]  in_char;

    assign in_func   = func_t'(s_tuser);
    assign in_state  = s_tdata[5:0];
    assign in_slot   = s_tdata[8:6];
    assign in_low    = s_tdata[24:9];
    assign in_high   = s_tdata[40:25];
    assign in_target = s_tdata[46:41];
    assign in_acc    = s_tdata[47];
    assign in_char   = s_tdata[63:48];

    st_t                   state_reg, state_next;
    logic [CHAR_BITS-1:0]  char_reg, char_next;
    logic [STATE_BITS-1:0] ld_state_reg, ld_state_next;
    logic                  ld_acc_reg, ld_acc_next;

    logic [STATE_BITS-1:0] cur_reg, cur_next;
    logic                  in_match_reg, in_match_next;
    logic [POS_BITS-1:0]   mbeg_reg, mbeg_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic                  best_valid_reg, best_valid_next;
    logic [POS_BITS-1:0]   best_start_reg, best_start_next;
    logic [POS_BITS-1:0]   best_len_reg, best_len_next;
    logic [STATE_BITS-1:0] best_state_reg, best_state_next;
    logic                  reported_reg, reported_next;
    // accepting check of the state just entered, resolved at its next read
    logic                  pend_reg, pend_next;
    logic [POS_BITS-1:0]   cand_len_reg, cand_len_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0]   m_data_reg, m_data_next;

    tbl_req_t              tbl_req;
    row_t                  rd_row;
    logic                  rd_acc;
    logic                  tbl_busy;

    drs_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rd_row  (rd_row),
        .rd_acc  (rd_acc),
        .busy    (tbl_busy)
    );

    logic                  s_fire;
    logic                  out_free;
    logic                  acc_cur;
    logic                  hit;
    logic [STATE_BITS-1:0] hit_target;
    logic [POS_BITS-1:0]   mbeg_new;
    logic [POS_BITS:0]     len_wide;
    logic [POS_BITS-1:0]   len_new;
    logic [POS_BITS-1:0]   pos_inc;
    logic                  eot_valid;
    logic [POS_BITS-1:0]   eot_start;
    logic [POS_BITS-1:0]   eot_len;
    logic [STATE_BITS-1:0] eot_state;

    assign s_tready = (state_reg == ST_IDLE) && !tbl_busy;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign acc_cur  = rd_acc && (cur_reg != '0);

    // first slot of the row whose range holds the character
    always_comb begin
        hit        = 1'b0;
        hit_target = '0;
        for (int k = 0; k < SLOTS_PER_STATE; k++) begin
            if (!hit && rd_row[k].valid && char_reg >= rd_row[k].low
                && char_reg <= rd_row[k].high) begin
                hit        = 1'b1;
                hit_target = rd_row[k].target;
            end
        end
    end

    assign mbeg_new = in_match_reg ? mbeg_reg : pos_reg;
    assign len_wide = {1'b0, pos_reg} + 1'b1 - {1'b0, mbeg_new};
    assign len_new  = len_wide[POS_BITS] ? POS_MAX : len_wide[POS_BITS-1:0];
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    // end of text view with the open check folded in
    always_comb begin
        eot_valid = best_valid_reg;
        eot_start = best_start_reg;
        eot_len   = best_len_reg;
        eot_state = best_state_reg;
        if (pend_reg && acc_cur) begin
            eot_valid = 1'b1;
            eot_start = mbeg_reg;
            eot_len   = cand_len_reg;
            eot_state = cur_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        char_next       = char_reg;
        ld_state_next   = ld_state_reg;
        ld_acc_next     = ld_acc_reg;
        cur_next        = cur_reg;
        in_match_next   = in_match_reg;
        mbeg_next       = mbeg_reg;
        pos_next        = pos_reg;
        best_valid_next = best_valid_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        best_state_next = best_state_reg;
        reported_next   = reported_reg;
        pend_next       = pend_reg;
        cand_len_next   = cand_len_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        tbl_req          = '0;
        tbl_req.rd_state = cur_reg;
        tbl_req.wr_state = in_state;
        tbl_req.wr_lane  = in_slot;
        tbl_req.wr_slot  = '{valid: 1'b1, low: in_low, high: in_high, target: in_target};
        tbl_req.wr_acc   = in_acc;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    char_next     = in_char;
                    ld_state_next = in_state;
                    ld_acc_next   = in_acc;
                    case (in_func)
                        FUNC_LOAD_SLOT: begin
                            tbl_req.slot_we = 1'b1;
                        end
                        FUNC_LOAD_FLAG: begin
                            if (pend_reg) begin
                                tbl_req.rd_en = 1'b1;
                                state_next    = ST_FLAG;
                            end else begin
                                tbl_req.acc_we = 1'b1;
                            end
                        end
                        FUNC_TEXT: begin
                            if (!reported_reg) begin
                                tbl_req.rd_en = 1'b1;
                                state_next    = ST_LOOK;
                            end
                        end
                        FUNC_END: begin
                            if (reported_reg) begin
                                cur_next        = '0;
                                in_match_next   = 1'b0;
                                mbeg_next       = '0;
                                pos_next        = '0;
                                best_valid_next = 1'b0;
                                best_start_next = '0;
                                best_len_next   = '0;
                                best_state_next = '0;
                                reported_next   = 1'b0;
                                pend_next       = 1'b0;
                            end else begin
                                tbl_req.rd_en = 1'b1;
                                state_next    = ST_EOT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_LOOK: begin
                if (hit || !acc_cur || out_free) begin
                    pend_next = 1'b0;
                    if (pend_reg && acc_cur) begin
                        best_valid_next = 1'b1;
                        best_start_next = mbeg_reg;
                        best_len_next   = cand_len_reg;
                        best_state_next = cur_reg;
                    end
                    state_next = ST_IDLE;
                    if (hit) begin
                        cur_next      = hit_target;
                        in_match_next = 1'b1;
                        mbeg_next     = mbeg_new;
                        pos_next      = pos_inc;
                        pend_next     = (hit_target != '0);
                        cand_len_next = len_new;
                    end else if (acc_cur) begin
                        // immediate report, failing character not counted
                        m_valid_next  = 1'b1;
                        m_data_next   = {1'b0, cur_reg, POS_BITS'(pos_reg - mbeg_reg),
                                         mbeg_reg, 1'b1};
                        reported_next = 1'b1;
                    end else if (in_match_reg) begin
                        in_match_next    = 1'b0;
                        cur_next         = '0;
                        tbl_req.rd_en    = 1'b1;
                        tbl_req.rd_state = '0;
                        state_next       = ST_RETRY;
                    end else begin
                        cur_next = '0;
                        pos_next = pos_inc;
                    end
                end
            end

            ST_RETRY: begin
                state_next = ST_IDLE;
                pos_next   = pos_inc;
                if (hit) begin
                    cur_next      = hit_target;
                    in_match_next = 1'b1;
                    mbeg_next     = mbeg_new;
                    pend_next     = (hit_target != '0);
                    cand_len_next = len_new;
                end
            end

            ST_FLAG: begin
                pend_next = 1'b0;
                if (acc_cur) begin
                    best_valid_next = 1'b1;
                    best_start_next = mbeg_reg;
                    best_len_next   = cand_len_reg;
                    best_state_next = cur_reg;
                end
                tbl_req.acc_we   = 1'b1;
                tbl_req.wr_state = ld_state_reg;
                tbl_req.wr_acc   = ld_acc_reg;
                state_next       = ST_IDLE;
            end

            ST_EOT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (eot_valid) begin
                        m_data_next = {1'b0, eot_state, eot_len, eot_start, 1'b1};
                    end else begin
                        m_data_next = {1'b0, cur_reg, {POS_BITS{1'b0}},
                                       {POS_BITS{1'b0}}, 1'b0};
                    end
                    cur_next        = '0;
                    in_match_next   = 1'b0;
                    mbeg_next       = '0;
                    pos_next        = '0;
                    best_valid_next = 1'b0;
                    best_start_next = '0;
                    best_len_next   = '0;
                    best_state_next = '0;
                    reported_next   = 1'b0;
                    pend_next       = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            in_match_reg   <= 1'b0;
            mbeg_reg       <= '0;
            pos_reg        <= '0;
            best_valid_reg <= 1'b0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            best_state_reg <= '0;
            reported_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            in_match_reg   <= in_match_next;
            mbeg_reg       <= mbeg_next;
            pos_reg        <= pos_next;
            best_valid_reg <= best_valid_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            best_state_reg <= best_state_next;
            reported_reg   <= reported_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        ld_state_reg <= ld_state_next;
        ld_acc_reg   <= ld_acc_next;
        cand_len_reg <= cand_len_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // outside an attempt the scan sits in state 0
    a_idle_state_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_match_reg |-> cur_reg == '0)
        else $error("scan outside a match left state 0");

    // an open accepting check always belongs to a nonzero state
    a_pend_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> cur_reg != '0)
        else $error("open accepting check on state 0");

    a_best_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        best_valid_reg |-> best_state_reg != '0)
        else $error("best point recorded in state 0");

    // no character is looked up after the text was reported
    a_no_look_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |-> !reported_reg)
        else $error("character scanned after report");

    a_no_item_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_busy |-> !s_tready)
        else $error("item taken during table clear");

    // a retry always follows a failed lookup within a match
    a_retry_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RETRY) |-> $past(state_reg) == ST_LOOK && $past(in_match_reg))
        else $error("retry without a dropped attempt");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the range based dfa scanner. Items carry table
// loads, text characters and end of text. A built-in predictor keeps its own
// table and scan state, queues the report each item should cause, and a
// monitor compares every accepted report field by field. Covered: an empty
// table, directed corner cases and random tables with random texts, with and
// without random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import drs_pkg::*;

    localparam int SLOT_COUNT  = NUM_STATES * SLOTS_PER_STATE;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 16;

    typedef struct packed {
        logic                  found;
        logic [POS_BITS-1:0]   start;
        logic [POS_BITS-1:0]   length;
        logic [STATE_BITS-1:0] end_state;
    } scan_report_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = FUNC_LOAD_SLOT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    dfa_range_regex_scanner_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // predictor copy of the table and the scan state
    logic [CHAR_BITS-1:0]  slot_lo  [SLOT_COUNT];
    logic [CHAR_BITS-1:0]  slot_hi  [SLOT_COUNT];
    logic [STATE_BITS-1:0] slot_tgt [SLOT_COUNT];
    bit                    slot_used [SLOT_COUNT];
    bit                    accept_flag [NUM_STATES];
    bit [STATE_BITS-1:0]   cur_state;
    bit                    in_match;
    int unsigned           match_begin;
    int unsigned           text_pos;
    bit                    best_valid;
    int unsigned           best_start;
    int unsigned           best_length;
    bit [STATE_BITS-1:0]   best_state;
    bit                    reported;

    scan_report_t reports_due [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           idle_on = 1'b0;
    int           stall_left = 0;

    function automatic int unsigned sat_pos(int unsigned v);
        return (v > POS_MAX) ? POS_MAX : v;
    endfunction

    function automatic bit state_accepts(bit [STATE_BITS-1:0] st);
        return (st != 0) && accept_flag[st];
    endfunction

    // first used slot whose range holds the character, -1 if none
    function automatic int next_state(bit [STATE_BITS-1:0] st, logic [CHAR_BITS-1:0] ch);
        int idx;
        for (int k = 0; k < SLOTS_PER_STATE; k++) begin
            idx = st * SLOTS_PER_STATE + k;
            if (slot_used[idx] && ch >= slot_lo[idx] && ch <= slot_hi[idx])
                return slot_tgt[idx];
        end
        return -1;
    endfunction

    function automatic scan_report_t make_report(bit f, int unsigned st, int unsigned len,
                                                 bit [STATE_BITS-1:0] es);
        scan_report_t r;
        r.found     = f;
        r.start     = st[POS_BITS-1:0];
        r.length    = len[POS_BITS-1:0];
        r.end_state = es;
        return r;
    endfunction

    // append at the tail of the expected queue
    function automatic void expect_report(scan_report_t r);
        reports_due.insert(reports_due.size(), r);
    endfunction

    function automatic void predict_item(func_t f, logic [63:0] d);
        int          idx;
        int          t;
        int unsigned p;
        logic [CHAR_BITS-1:0] ch;
        case (f)
            FUNC_LOAD_SLOT: begin
                idx = d[5:0] * SLOTS_PER_STATE + d[8:6];
                slot_lo[idx]   = d[24:9];
                slot_hi[idx]   = d[40:25];
                slot_tgt[idx]  = d[46:41];
                slot_used[idx] = 1'b1;
            end
            FUNC_LOAD_FLAG: begin
                accept_flag[d[5:0]] = d[47];
            end
            FUNC_TEXT: begin
                if (!reported) begin
                    ch = d[63:48];
                    p  = text_pos;
                    t  = next_state(cur_state, ch);
                    if (t < 0 && state_accepts(cur_state)) begin
                        expect_report(make_report(1'b1, match_begin,
                                                  sat_pos(p - match_begin), cur_state));
                        reported = 1'b1;
                    end else begin
                        // failed attempt: retry the same character from state 0
                        if (t < 0 && in_match) begin
                            in_match  = 1'b0;
                            cur_state = '0;
                            t = next_state('0, ch);
                        end
                        if (t >= 0) begin
                            cur_state = STATE_BITS'(t);
                            if (!in_match) begin
                                in_match    = 1'b1;
                                match_begin = p;
                            end
                        end else begin
                            cur_state = '0;
                            in_match  = 1'b0;
                        end
                        text_pos = (p < POS_MAX) ? p + 1 : p;
                        if (state_accepts(cur_state)) begin
                            best_valid  = 1'b1;
                            best_start  = match_begin;
                            best_length = sat_pos(p + 1 - match_begin);
                            best_state  = cur_state;
                        end
                    end
                end
            end
            default: begin
                if (!reported) begin
                    if (best_valid)
                        expect_report(make_report(1'b1, best_start, best_length,
                                                  best_state));
                    else
                        expect_report(make_report(1'b0, 0, 0, cur_state));
                end
                cur_state   = '0;
                in_match    = 1'b0;
                match_begin = 0;
                text_pos    = 0;
                best_valid  = 1'b0;
                best_start  = 0;
                best_length = 0;
                best_state  = '0;
                reported    = 1'b0;
            end
        endcase
    endfunction

    function automatic logic [63:0] pack_item(logic [5:0] st, logic [2:0] sl, logic [15:0] lo,
                                              logic [15:0] hi, logic [5:0] tg, logic acc,
                                              logic [15:0] ch);
        return {ch, acc, tg, hi, lo, sl, st};
    endfunction

    task automatic send_item(func_t f, logic [63:0] d);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= f;
        predict_item(f, d);
        do @(posedge aclk); while (!s_tready);
    endtask

    // unused fields get random bits so that they toggle too
    task automatic load_slot(logic [5:0] st, logic [2:0] sl, logic [15:0] lo, logic [15:0] hi,
                             logic [5:0] tg);
        send_item(FUNC_LOAD_SLOT, pack_item(st, sl, lo, hi, tg, 1'($urandom),
                                            16'($urandom)));
    endtask

    task automatic load_flag(logic [5:0] st, logic acc);
        send_item(FUNC_LOAD_FLAG, pack_item(st, 3'($urandom), 16'($urandom), 16'($urandom),
                                            6'($urandom), acc, 16'($urandom)));
    endtask

    task automatic text_char(logic [15:0] ch);
        send_item(FUNC_TEXT, pack_item(6'($urandom), 3'($urandom), 16'($urandom),
                                       16'($urandom), 6'($urandom), 1'($urandom), ch));
    endtask

    task automatic end_text();
        send_item(FUNC_END, {$urandom, $urandom});
    endtask

    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endtask

    // receiver side: random stall bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        scan_report_t got;
        scan_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.found     = m_tdata[0];
            got.start     = m_tdata[16:1];
            got.length    = m_tdata[32:17];
            got.end_state = m_tdata[38:33];
            if (reports_due.size() == 0) begin
                report_mismatch("unexpected report", '0, m_tdata[15:0]);
            end else begin
                want = reports_due.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", 16'(want.found), 16'(got.found));
                if (got.start !== want.start)
                    report_mismatch("match_start", want.start, got.start);
                if (got.length !== want.length)
                    report_mismatch("match_length", want.length, got.length);
                if (got.end_state !== want.end_state)
                    report_mismatch("end_state", 16'(want.end_state), 16'(got.end_state));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic test_empty_table();
        text_char(16'h0041);
        text_char(16'hFFFF);
        end_text();
        end_text();
    endtask

    task automatic test_directed_matches();
        // extremes: slot 7 of state 0 on char 0, state 63 loops on ffff
        load_slot(6'd0, 3'd7, 16'h0000, 16'h0000, 6'd63);
        load_slot(6'd63, 3'd0, 16'hFFFF, 16'hFFFF, 6'd63);
        load_flag(6'd63, 1'b1);
        // accept flag of state 0 has no effect
        load_flag(6'd0, 1'b1);
        text_char(16'h0000);
        text_char(16'hFFFF);
        text_char(16'h1234);   // immediate report
        text_char(16'h0000);   // ignored after report
        end_text();            // no report
        text_char(16'hFFFF);
        text_char(16'h0000);
        end_text();
        // reversed range never matches, unloaded slots skipped
        load_slot(6'd0, 3'd2, 16'h0050, 16'h0040, 6'd10);
        text_char(16'h0045);
        end_text();
        // failed attempt retried from state 0
        load_slot(6'd0, 3'd3, 16'h0061, 16'h0061, 6'd1);
        load_slot(6'd1, 3'd0, 16'h0062, 16'h0062, 6'd2);
        load_flag(6'd2, 1'b1);
        text_char(16'h0061);
        text_char(16'h0061);
        text_char(16'h0062);
        text_char(16'h0063);
        end_text();
        // flag load in the middle of a text acts at once
        text_char(16'h0061);
        load_flag(6'd1, 1'b1);
        text_char(16'h0078);
        end_text();
        load_flag(6'd1, 1'b0);
        text_char(16'h0061);
        end_text();
    endtask

    task automatic test_random_scans(int item_goal, bit with_idle);
        int          sent;
        int          n_states;
        int          n_slots;
        int          n_texts;
        int          text_len;
        logic [5:0]  phys [8];
        logic [5:0]  tg;
        logic [15:0] base;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] ch;
        idle_on = with_idle;
        sent = 0;
        while (sent < item_goal) begin
            n_states = $urandom_range(2, 8);
            base = 16'($urandom_range(0, 16'hFFEF));
            phys[0] = '0;
            for (int i = 1; i < n_states; i++)
                phys[i] = 6'($urandom_range(1, 63));
            for (int i = 0; i < n_states; i++) begin
                n_slots = $urandom_range(1, 8);
                for (int j = 0; j < n_slots; j++) begin
                    lo = base + 16'($urandom_range(0, 15));
                    hi = lo + 16'($urandom_range(0, 3));
                    case ($urandom_range(0, 9))
                        0: begin
                            lo = 16'($urandom);
                            hi = 16'($urandom);
                        end
                        1: {lo, hi} = {hi, lo};
                        2: begin
                            lo = 16'h0000;
                            hi = 16'hFFFF;
                        end
                        default: ;
                    endcase
                    tg = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                     : phys[$urandom_range(0, n_states - 1)];
                    load_slot(phys[i], 3'($urandom_range(0, 7)), lo, hi, tg);
                    sent++;
                end
                load_flag(phys[i], 1'($urandom_range(0, 1)));
                sent++;
            end
            n_texts = $urandom_range(2, 6);
            for (int t = 0; t < n_texts; t++) begin
                text_len = $urandom_range(0, 20);
                for (int c = 0; c < text_len; c++) begin
                    // noise item of any kind now and then
                    if ($urandom_range(0, 19) == 0)
                        send_item(func_t'($urandom_range(0, 3)), {$urandom, $urandom});
                    ch = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                      : base + 16'($urandom_range(0, 15));
                    text_char(ch);
                    sent++;
                end
                end_text();
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;
        test_empty_table();
        test_directed_matches();
        test_random_scans(750, 1'b1);
        test_random_scans(150, 1'b0);
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && reports_due.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
